// ===== design/bbpt_pkg.sv =====
`timescale 1ns / 1ps
package bbpt_pkg;
  localparam int MAX_BEATS_DEF = 4096;
  localparam int TIME_BITS_DEF = 24;
  localparam int CNT_W = 13;
  localparam int IDX_W = 12;
  localparam int TMS_W = 24;
  localparam int BN_W = 4;
  localparam int BAR_W = 16;
  localparam int FRAC_W = 17;
  localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;
  localparam logic [BAR_W-1:0] BAR_MAX = 16'hFFFF;
  localparam logic [BN_W-1:0] DOWNBEAT = 4'd1;

  typedef struct packed {
    logic req_type;
    logic [TMS_W-1:0] time_ms;
    logic [IDX_W-1:0] entry_index;
    logic [BN_W-1:0] beat_in_bar;
  } bbpt_in_t;

  typedef struct packed {
    logic beat_trigger;
    logic bar_trigger;
    logic [BAR_W-1:0] bar_number;
    logic [BN_W-1:0] beat_number;
    logic [FRAC_W-1:0] beat_fraction;
    logic [FRAC_W-1:0] bar_fraction;
  } bbpt_out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_CHK0, S_HINT0, S_HINT1, S_SCAN, S_BACK, S_FWD,
    S_NEXT, S_DIVB, S_DIVR, S_OUT
  } bbpt_state_t;
endpackage

// ===== design/bar_beat_position_tracker.sv =====
`timescale 1ns / 1ps
// Tick: the hint check (skipped when entry_count < 2), then the scan and the backward
// and forward walks read the table entry by entry, and each fraction goes through the
// serial divider, which is skipped when the fraction saturates. Throughput: loads one
// per cycle while no tick is in progress; ticks one at a time, the next transaction is
// taken once the result register is loaded; a stalled result holds the following tick.
// Reset: synchronous, active low; clears bar counter, hint, previous time, entry_count.
module bar_beat_position_tracker #(
  parameter int MAX_BEATS = bbpt_pkg::MAX_BEATS_DEF,
  parameter int TIME_BITS = bbpt_pkg::TIME_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  bbpt_pkg::bbpt_in_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output bbpt_pkg::bbpt_out_t out_data,
  input  logic cfg_we,
  input  logic [bbpt_pkg::CNT_W-1:0] cfg_wdata
);
  import bbpt_pkg::*;
  localparam int AW = $clog2(MAX_BEATS);
  localparam int NW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
  localparam int TW = TIME_BITS;
  localparam logic [4:0] DIV_STEPS = 5'd16;

  // table memory: time, beat number, bar number per entry
  logic [TW-1:0] tmem [MAX_BEATS];
  logic [BN_W-1:0] nmem [MAX_BEATS];
  logic [BAR_W-1:0] bmem [MAX_BEATS];
  logic [TW-1:0] rd_t;
  logic [BN_W-1:0] rd_n;
  logic [BAR_W-1:0] rd_b;
  logic [AW-1:0] ra;
  logic we;
  logic [AW-1:0] wa;

  bbpt_state_t st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [BAR_W-1:0] lbar_r, lbar_w;
  logic [NW-1:0] hint_r, i_r, idx_r;
  logic [NW-1:0] n_w, h_w;
  logic [TW-1:0] prev_r, t_r, th_r, tidx_r, tnext_r, bstart_r, bend_r;
  logic [TW-1:0] tin;
  logic [BN_W-1:0] bnidx_r;
  logic [BAR_W-1:0] baridx_r;
  logic hasnext_r, barnext_r, empty_r, trig_r, ph_r;
  // serial divider
  logic [TW:0] rem_r, rem_sh;
  logic [TW-1:0] den_r;
  logic [15:0] q_r;
  logic [4:0] dc_r;
  logic dsk_r, div_ge;
  logic [FRAC_W-1:0] bfrac_r, rfrac_r, b_val, r_val;
  logic b_fix, r_fix;
  logic ov_r, acc, is_empty, hint_hit;
  bbpt_out_t od_r, res_w;

  assign tin = TW'(in_data.time_ms);
  // entry_count above the table size acts as the table size
  assign n_w = (NW'(cnt_r) > NW'(MAX_BEATS)) ? NW'(MAX_BEATS) : NW'(cnt_r);
  // hint clamped to n - 2; only used when n >= 2
  assign h_w = (hint_r > n_w - NW'(2)) ? n_w - NW'(2) : hint_r;

  assign acc = in_valid && !in_stall;
  assign we = acc && in_data.req_type;
  assign wa = AW'(in_data.entry_index % MAX_BEATS);

  // bar count for a load: slot 0 restarts counting, downbeats count up, saturating
  always_comb begin
    lbar_w = (wa == '0) ? '0 : lbar_r;
    if (in_data.beat_in_bar == DOWNBEAT && lbar_w != BAR_MAX) lbar_w = lbar_w + BAR_W'(1);
  end

  always_ff @(posedge clk) begin
    if (we) begin
      tmem[wa] <= tin;
      nmem[wa] <= in_data.beat_in_bar;
      bmem[wa] <= lbar_w;
    end
    rd_t <= tmem[ra];
    rd_n <= nmem[ra];
    rd_b <= bmem[ra];
  end

  // rd_* is entry 0 in S_CHK0, the hint entry in S_HINT0, entry h+1 in S_HINT1
  assign is_empty = (n_w == '0) || (t_r < rd_t);
  assign hint_hit = (th_r < t_r) && (rd_t > t_r);

  // restoring divide step: remainder always below the divisor
  assign rem_sh = {rem_r[TW-1:0], 1'b0};
  assign div_ge = rem_sh >= {1'b0, den_r};

  // fraction special cases: missing successor or t at/after it -> 1.0, t before start -> 0
  always_comb begin
    b_fix = !hasnext_r || (t_r < tidx_r) || (tnext_r <= tidx_r) || (t_r >= tnext_r);
    b_val = (hasnext_r && t_r < tidx_r) ? '0 : ONE_Q16;
    r_fix = !barnext_r || (t_r < bstart_r) || (bend_r <= bstart_r) || (t_r >= bend_r);
    r_val = (barnext_r && t_r < bstart_r) ? '0 : ONE_Q16;
  end

  always_comb begin
    res_w = '0;
    if (!empty_r) begin
      res_w.beat_trigger = trig_r;
      res_w.bar_trigger = trig_r && bnidx_r == DOWNBEAT;
      res_w.bar_number = baridx_r;
      res_w.beat_number = bnidx_r;
      res_w.beat_fraction = bfrac_r;
      res_w.bar_fraction = rfrac_r;
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (acc && !in_data.req_type) st_nxt = S_RD0;
      S_RD0: st_nxt = S_CHK0;
      S_CHK0: begin
        if (is_empty) st_nxt = S_OUT;
        else if (n_w >= NW'(2)) st_nxt = S_HINT0;
        else st_nxt = S_BACK;
      end
      S_HINT0: st_nxt = S_HINT1;
      S_HINT1: st_nxt = hint_hit ? S_BACK : S_SCAN;
      S_SCAN: begin
        if (!ph_r && i_r >= n_w) st_nxt = S_BACK;
        else if (ph_r && rd_t > t_r) st_nxt = S_BACK;
      end
      S_BACK: if (ph_r && (rd_n == DOWNBEAT || i_r == '0)) st_nxt = S_FWD;
      S_FWD: begin
        if (!ph_r && i_r >= n_w) st_nxt = S_NEXT;
        else if (ph_r && rd_b != baridx_r) st_nxt = S_NEXT;
      end
      S_NEXT: st_nxt = S_DIVB;
      S_DIVB: if (dc_r == DIV_STEPS) st_nxt = S_DIVR;
      S_DIVR: if (dc_r == DIV_STEPS) st_nxt = S_OUT;
      S_OUT: if (!ov_r || !out_stall) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // outputs: input stall and table read address
  always_comb begin
    in_stall = (st_r != S_IDLE);
    unique case (st_r)
      S_CHK0: ra = AW'(h_w);
      S_HINT0: ra = AW'(h_w + NW'(1));
      S_SCAN, S_BACK, S_FWD: ra = AW'(i_r);
      default: ra = '0;
    endcase
  end

  // datapath; ph_r: 0 = address out, 1 = read data of entry i_r present
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
      lbar_r <= '0;
      hint_r <= '0;
      prev_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) cnt_r <= cfg_wdata;
      if (we) lbar_r <= lbar_w;
      if (st_r == S_OUT && (!ov_r || !out_stall)) ov_r <= 1'b1;
      else if (ov_r && !out_stall) ov_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (acc && !in_data.req_type) t_r <= tin;
        S_CHK0: begin
          empty_r <= is_empty;
          if (is_empty) begin
            prev_r <= t_r;      // hint left as is
          end else if (n_w < NW'(2)) begin
            idx_r <= '0; i_r <= '0; hasnext_r <= 1'b0; ph_r <= 1'b0;
          end
        end
        S_HINT0: th_r <= rd_t;
        S_HINT1: begin
          ph_r <= 1'b0;
          if (hint_hit) begin
            idx_r <= h_w; i_r <= h_w; tnext_r <= rd_t; hasnext_r <= 1'b1;
          end else begin
            i_r <= NW'(1);
          end
        end
        S_SCAN: begin
          // first entry later than t; the one before it is the current beat
          if (!ph_r) begin
            if (i_r >= n_w) begin
              idx_r <= i_r - NW'(1); i_r <= i_r - NW'(1); hasnext_r <= 1'b0;
            end else ph_r <= 1'b1;
          end else begin
            ph_r <= 1'b0;
            if (rd_t > t_r) begin
              idx_r <= i_r - NW'(1); i_r <= i_r - NW'(1);
              tnext_r <= rd_t; hasnext_r <= 1'b1;
            end else i_r <= i_r + NW'(1);
          end
        end
        S_BACK: begin
          // walk down to the last downbeat; entry 0 is the fallback bar start
          if (!ph_r) begin
            ph_r <= 1'b1;
          end else begin
            ph_r <= 1'b0;
            if (i_r == idx_r) begin
              bnidx_r <= rd_n; baridx_r <= rd_b; tidx_r <= rd_t;
            end
            if (rd_n == DOWNBEAT || i_r == '0) begin
              bstart_r <= rd_t; i_r <= idx_r + NW'(1);
            end else i_r <= i_r - NW'(1);
          end
        end
        S_FWD: begin
          // walk up to the first entry of the next bar
          if (!ph_r) begin
            if (i_r >= n_w) barnext_r <= 1'b0;
            else ph_r <= 1'b1;
          end else begin
            ph_r <= 1'b0;
            if (rd_b != baridx_r) begin
              bend_r <= rd_t; barnext_r <= 1'b1;
            end else i_r <= i_r + NW'(1);
          end
        end
        S_NEXT: begin
          trig_r <= (tidx_r >= prev_r);
          prev_r <= t_r;
          hint_r <= idx_r;
          // beat fraction setup
          bfrac_r <= b_val;
          dsk_r <= b_fix;
          dc_r <= b_fix ? DIV_STEPS : 5'd0;
          rem_r <= {1'b0, t_r - tidx_r};
          den_r <= tnext_r - tidx_r;
          q_r <= '0;
        end
        S_DIVB: begin
          if (dc_r != DIV_STEPS) begin
            rem_r <= div_ge ? rem_sh - {1'b0, den_r} : rem_sh;
            q_r <= {q_r[14:0], div_ge};
            dc_r <= dc_r + 5'd1;
          end else begin
            if (!dsk_r) bfrac_r <= {1'b0, q_r};
            // bar fraction setup
            rfrac_r <= r_val;
            dsk_r <= r_fix;
            dc_r <= r_fix ? DIV_STEPS : 5'd0;
            rem_r <= {1'b0, t_r - bstart_r};
            den_r <= bend_r - bstart_r;
            q_r <= '0;
          end
        end
        S_DIVR: begin
          if (dc_r != DIV_STEPS) begin
            rem_r <= div_ge ? rem_sh - {1'b0, den_r} : rem_sh;
            q_r <= {q_r[14:0], div_ge};
            dc_r <= dc_r + 5'd1;
          end else if (!dsk_r) rfrac_r <= {1'b0, q_r};
        end
        S_OUT: if (!ov_r || !out_stall) od_r <= res_w;
        default: ;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_data = od_r;

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> in_stall) else $error("accepted while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> (ov_r && $stable(out_data))) else $error("result dropped");
  a_bar: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (!out_data.bar_trigger || out_data.beat_trigger)) else $error("bar w/o beat");
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_NEXT) |-> (idx_r < n_w)) else $error("beat index past table");
`endif
endmodule
